### hdl/rgb_linear_fade_engine_defines.svh
// Assertion macros used by the checker file of the RGB fade engine.
`ifndef RGB_LINEAR_FADE_ENGINE_DEFINES_SVH
`define RGB_LINEAR_FADE_ENGINE_DEFINES_SVH

// Check a property on clk, off while rst_n is low.
`define RLF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rgb fade engine check failed");

// Check a property on clk, also during reset.
`define RLF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("rgb fade engine check failed");

`endif

### hdl/rlf_pkg.sv
// Types and constants of the RGB linear fade engine.
`timescale 1ns / 1ps

package rlf_pkg;

  localparam int CHAN_W = 8;
  localparam int STEP_W = 8;
  localparam int NUM_CHAN = 3;

  localparam logic [STEP_W-1:0] FADE_STEPS_RESET = 8'd100;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_FORCE = 2'd1;
  localparam logic [1:0] MODE_COND = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_duty;
    logic [CHAN_W-1:0] green_duty;
    logic [CHAN_W-1:0] blue_duty;
    logic              fade_done;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
  } lane_ctl_t;

endpackage

### hdl/rlf_lane.sv
// One color lane: bit-serial weighted sum followed by bit-serial restoring divide.
`timescale 1ns / 1ps

module rlf_lane (
  input  logic                        clk,
  input  rlf_pkg::lane_ctl_t          ctl,
  input  logic [rlf_pkg::CHAN_W-1:0]  start_lvl,
  input  logic [rlf_pkg::CHAN_W-1:0]  target_lvl,
  input  logic [rlf_pkg::STEP_W-1:0]  wgt_start,
  input  logic [rlf_pkg::STEP_W-1:0]  wgt_target,
  input  logic [rlf_pkg::STEP_W-1:0]  divisor,
  output logic [rlf_pkg::CHAN_W-1:0]  quot
);

  localparam int CW = rlf_pkg::CHAN_W;
  localparam int SW = rlf_pkg::STEP_W;
  localparam int AW = CW + SW;

  logic [AW-1:0] acc_r, acc_nxt;
  logic [SW-1:0] wa_r, wb_r;
  logic [AW-1:0] mul_sum;
  logic [SW:0]   trial;
  logic [SW:0]   rem;
  logic          ge;

  // MSB-first shift-and-add over the weight bits
  always_comb begin
    mul_sum = {acc_r[AW-2:0], 1'b0}
            + (wa_r[SW-1] ? {{SW{1'b0}}, start_lvl} : '0)
            + (wb_r[SW-1] ? {{SW{1'b0}}, target_lvl} : '0);
  end

  // upper half holds the partial remainder, already below the divisor
  always_comb begin
    trial = {acc_r[AW-1:CW], acc_r[CW-1]};
    ge    = (trial >= {1'b0, divisor});
    rem   = ge ? (trial - {1'b0, divisor}) : trial;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.load) begin
      acc_nxt = '0;
    end else if (ctl.mul) begin
      acc_nxt = mul_sum;
    end else if (ctl.div) begin
      acc_nxt = {rem[SW-1:0], acc_r[CW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctl.load) begin
      wa_r <= wgt_start;
      wb_r <= wgt_target;
    end else if (ctl.mul) begin
      wa_r <= {wa_r[SW-2:0], 1'b0};
      wb_r <= {wb_r[SW-2:0], 1'b0};
    end
  end

  assign quot = acc_r[CW-1:0];

endmodule

### hdl/rgb_linear_fade_engine.sv
// Top level of the RGB linear fade engine: fade state, sequencer and result register.
`timescale 1ns / 1ps

// Usage:
//   in_valid/in_ready carry one in_data word: a tick, a forced set-target or a
//   conditional set-target. Set words never make the engine busy and give no result.
//   A tick while a fade runs gives one out_data word on out_valid/out_ready with
//   the three interpolated duties and fade_done on the last step of the fade.
//   A tick while idle, and mode three, are dropped without a result.
//   cfg_we/cfg_wdata write the fade length used by the next set-target word.
// Sequence:
//   A tick loads the lanes at its accepting edge, then runs a bit-serial
//   multiply, a bit-serial divide and a final state that stores the result
//   and raises out_valid. The three channels run in parallel lanes. in_ready
//   is low while a tick is being worked, so the next word waits until the
//   result is stored.
// Reset (rst_n, synchronous): idle, no fade, start color black, fade length 100.
// Stall: a finished result waits in the output register; the engine takes the
//   next word meanwhile, and a following tick holds in its last cycle until the
//   output register is free.
module rgb_linear_fade_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rlf_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rlf_pkg::out_word_t               out_data,
  input  logic                             cfg_we,
  input  logic [rlf_pkg::STEP_W-1:0]       cfg_wdata
);

  localparam int CW = rlf_pkg::CHAN_W;
  localparam int SW = rlf_pkg::STEP_W;
  localparam int NC = rlf_pkg::NUM_CHAN;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [SW-1:0]          fade_steps_r;
  logic [NC-1:0][CW-1:0]  start_r;
  logic [NC-1:0][CW-1:0]  target_r;
  logic                   fading_r;
  logic [SW-1:0]          step_r;
  logic [SW-1:0]          len_r;
  logic                   last_r;
  logic                   out_valid_r;
  rlf_pkg::out_word_t     out_data_r;

  logic [NC-1:0][CW-1:0]  in_col;
  logic [NC-1:0][CW-1:0]  quot;
  logic                   accept;
  logic                   tick_go;
  logic                   set_go;
  logic                   fin_go;
  logic                   differs;
  rlf_pkg::lane_ctl_t     ctl;

  assign in_col  = {in_data.blue_in, in_data.green_in, in_data.red_in};
  assign in_ready = (state_r == ST_IDLE);
  assign accept  = in_valid && in_ready;
  assign differs = (in_col != start_r);
  assign tick_go = accept && (in_data.mode == rlf_pkg::MODE_TICK) && fading_r;
  assign set_go  = accept && ((in_data.mode == rlf_pkg::MODE_FORCE) ||
                   ((in_data.mode == rlf_pkg::MODE_COND) && !fading_r && differs));
  assign fin_go  = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  assign ctl.load = tick_go;
  assign ctl.mul  = (state_r == ST_MUL);
  assign ctl.div  = (state_r == ST_DIV);

  for (genvar c = 0; c < NC; c++) begin : g_lane
    rlf_lane u_lane (
      .clk        (clk),
      .ctl        (ctl),
      .start_lvl  (start_r[c]),
      .target_lvl (target_r[c]),
      .wgt_start  (len_r - step_r),
      .wgt_target (step_r),
      .divisor    (len_r),
      .quot       (quot[c])
    );
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_go) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(SW - 1)) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(CW - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      fade_steps_r <= rlf_pkg::FADE_STEPS_RESET;
      start_r      <= '0;
      fading_r     <= 1'b0;
      step_r       <= '0;
      len_r        <= rlf_pkg::FADE_STEPS_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        fade_steps_r <= cfg_wdata;
      end
      if (set_go) begin
        fading_r <= 1'b1;
        step_r   <= '0;
        len_r    <= (fade_steps_r == '0) ? SW'(1) : fade_steps_r;
      end
      if (fin_go) begin
        if (last_r) begin
          fading_r <= 1'b0;
          start_r  <= target_r;
        end else begin
          step_r <= step_r + SW'(1);
        end
      end
      priority if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (set_go) begin
      target_r <= in_col;
    end
    if (tick_go) begin
      last_r <= (step_r == len_r);
    end
    if (fin_go) begin
      out_data_r.red_duty   <= quot[0];
      out_data_r.green_duty <= quot[1];
      out_data_r.blue_duty  <= quot[2];
      out_data_r.fade_done  <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/rlf_checker.sv
// Port-level checks of the RGB fade engine and their binding to the top level.
`timescale 1ns / 1ps
`include "rgb_linear_fade_engine_defines.svh"

module rlf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input rlf_pkg::in_word_t           in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input rlf_pkg::out_word_t          out_data
);

  // a stalled result word holds
  `RLF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // words other than ticks, set or dropped, never make the engine busy
  `RLF_ASSERT(a_set_quick, in_valid && in_ready && in_data.mode != rlf_pkg::MODE_TICK |=> in_ready)

  // the engine goes busy only on a tick it took
  `RLF_ASSERT(a_busy_tick, $fell(in_ready) |-> $past(in_valid && in_data.mode == rlf_pkg::MODE_TICK))

  // a new result appears only at the end of a busy stretch
  `RLF_ASSERT(a_out_after_busy, $rose(out_valid) |-> $past(!in_ready))

endmodule

bind rgb_linear_fade_engine rlf_checker u_rlf_checker (.*);

### dv/tb_rgb_linear_fade_engine.sv
// Self-checking testbench for the RGB linear fade engine: predicted duties vs. DUT output.
`timescale 1ns / 1ps

module tb_rgb_linear_fade_engine;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CFG_SETTLE = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_PHASES = 9;
  localparam logic [rlf_pkg::STEP_W-1:0] PHASE_STEPS [NUM_PHASES] = '{
    8'd1, 8'd3, 8'd255, 8'd7, 8'd2, 8'd100, 8'd16, 8'd0, 8'd5};
  localparam int PHASE_WORDS [NUM_PHASES] = '{55, 65, 280, 65, 55, 65, 50, 45, 55};

  class duty_scoreboard;
    logic [rlf_pkg::STEP_W-1:0] steps_reg;
    logic [rlf_pkg::CHAN_W-1:0] start_lvl [rlf_pkg::NUM_CHAN];
    logic [rlf_pkg::CHAN_W-1:0] target_lvl [rlf_pkg::NUM_CHAN];
    bit                         fading;
    logic [rlf_pkg::STEP_W-1:0] step_cnt;
    logic [rlf_pkg::STEP_W-1:0] length;
    rlf_pkg::out_word_t         duty_q [$];
    int unsigned                n_err;
    int unsigned                n_checked;
    int unsigned                n_fades;
    int unsigned                n_loads;

    function new();
      steps_reg = rlf_pkg::FADE_STEPS_RESET;
      for (int c = 0; c < rlf_pkg::NUM_CHAN; c++) begin
        start_lvl[c] = '0;
        target_lvl[c] = '0;
      end
      fading = 1'b0;
      step_cnt = '0;
      length = rlf_pkg::FADE_STEPS_RESET;
      n_err = 0;
      n_checked = 0;
      n_fades = 0;
      n_loads = 0;
    endfunction

    function logic [rlf_pkg::CHAN_W-1:0] word_level(rlf_pkg::in_word_t w, int c);
      case (c)
        0: return w.red_in;
        1: return w.green_in;
        default: return w.blue_in;
      endcase
    endfunction

    function logic [rlf_pkg::CHAN_W-1:0] blend_level(logic [rlf_pkg::CHAN_W-1:0] from,
                                                     logic [rlf_pkg::CHAN_W-1:0] to,
                                                     logic [rlf_pkg::STEP_W-1:0] t,
                                                     logic [rlf_pkg::STEP_W-1:0] n);
      int unsigned acc;
      acc = 32'(from) * 32'(n - t) + 32'(to) * 32'(t);
      return rlf_pkg::CHAN_W'(acc / 32'(n));
    endfunction

    function void load_target(rlf_pkg::in_word_t w);
      for (int c = 0; c < rlf_pkg::NUM_CHAN; c++) target_lvl[c] = word_level(w, c);
      fading = 1'b1;
      step_cnt = '0;
      // a zero setting still fades over one step
      length = (steps_reg == '0) ? rlf_pkg::STEP_W'(1) : steps_reg;
      n_loads++;
    endfunction

    // Returns 1 when the word loads a fade or produces a duty word.
    function bit take_word(rlf_pkg::in_word_t w);
      logic [rlf_pkg::STEP_W-1:0] n;
      logic [rlf_pkg::STEP_W-1:0] t;
      rlf_pkg::out_word_t         exp_w;
      bit                         differs;
      differs = 1'b0;
      case (w.mode)
        rlf_pkg::MODE_FORCE: begin
          load_target(w);
          return 1'b1;
        end
        rlf_pkg::MODE_COND: begin
          if (fading) return 1'b0;
          for (int c = 0; c < rlf_pkg::NUM_CHAN; c++)
            if (word_level(w, c) != start_lvl[c]) differs = 1'b1;
          if (differs) load_target(w);
          return differs;
        end
        rlf_pkg::MODE_TICK: begin
          if (!fading) return 1'b0;
          n = (length == '0) ? rlf_pkg::STEP_W'(1) : length;
          t = (step_cnt > n) ? n : step_cnt;
          exp_w.red_duty = blend_level(start_lvl[0], target_lvl[0], t, n);
          exp_w.green_duty = blend_level(start_lvl[1], target_lvl[1], t, n);
          exp_w.blue_duty = blend_level(start_lvl[2], target_lvl[2], t, n);
          exp_w.fade_done = (t == n);
          duty_q.push_back(exp_w);
          if (t == n) begin
            fading = 1'b0;
            for (int c = 0; c < rlf_pkg::NUM_CHAN; c++) start_lvl[c] = target_lvl[c];
            step_cnt = t;
            n_fades++;
          end else begin
            step_cnt = t + 1'b1;
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void check_duty(rlf_pkg::out_word_t got);
      rlf_pkg::out_word_t exp_w;
      if (duty_q.size() == 0) begin
        $error("duty word with nothing pending: %h", got);
        n_err++;
        return;
      end
      exp_w = duty_q.pop_front();
      n_checked++;
      if (got.red_duty !== exp_w.red_duty) begin
        $error("red_duty: expected %0d, got %0d", exp_w.red_duty, got.red_duty);
        n_err++;
      end
      if (got.green_duty !== exp_w.green_duty) begin
        $error("green_duty: expected %0d, got %0d", exp_w.green_duty, got.green_duty);
        n_err++;
      end
      if (got.blue_duty !== exp_w.blue_duty) begin
        $error("blue_duty: expected %0d, got %0d", exp_w.blue_duty, got.blue_duty);
        n_err++;
      end
      if (got.fade_done !== exp_w.fade_done) begin
        $error("fade_done: expected %0d, got %0d", exp_w.fade_done, got.fade_done);
        n_err++;
      end
    endfunction

    function int pending();
      return duty_q.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  rlf_pkg::in_word_t          in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  rlf_pkg::out_word_t         out_data;
  logic                       cfg_we = 1'b0;
  logic [rlf_pkg::STEP_W-1:0] cfg_wdata = '0;

  duty_scoreboard sb;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_req = 1'b0;
  int  n_effective = 0;
  int  idle_cycles = 0;

  rgb_linear_fade_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rlf_pkg::in_word_t mk_word(logic [1:0] mode,
                                                logic [rlf_pkg::CHAN_W-1:0] r,
                                                logic [rlf_pkg::CHAN_W-1:0] g,
                                                logic [rlf_pkg::CHAN_W-1:0] b);
    rlf_pkg::in_word_t w;
    w.mode = mode;
    w.red_in = r;
    w.green_in = g;
    w.blue_in = b;
    return w;
  endfunction

  function automatic logic [rlf_pkg::CHAN_W-1:0] rand_level();
    logic [rlf_pkg::CHAN_W-1:0] v;
    v = rlf_pkg::CHAN_W'($urandom);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return v;
    endcase
  endfunction

  // Mostly well-formed traffic: ticks while a fade runs, set words while idle.
  function automatic rlf_pkg::in_word_t pick_word();
    rlf_pkg::in_word_t w;
    int                r;
    int                force_pct;
    w = mk_word(rlf_pkg::MODE_TICK, rand_level(), rand_level(), rand_level());
    r = $urandom_range(99);
    // long fades are left to finish so the late steps get exercised
    force_pct = (sb.length > 32) ? 0 : 6;
    if (sb.fading) begin
      if (r < 5) w.mode = rlf_pkg::MODE_COND;
      else if (r < 5 + force_pct) w.mode = rlf_pkg::MODE_FORCE;
      else if (r < 8 + force_pct) w.mode = MODE_SPARE;
    end else begin
      if (r < 50) begin
        w.mode = rlf_pkg::MODE_COND;
      end else if (r < 62) begin
        w = mk_word(rlf_pkg::MODE_COND, sb.start_lvl[0], sb.start_lvl[1], sb.start_lvl[2]);
      end else if (r < 80) begin
        w.mode = rlf_pkg::MODE_FORCE;
      end else if (r >= 95) begin
        w.mode = MODE_SPARE;
      end
    end
    return w;
  endfunction

  task automatic send_word(rlf_pkg::in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.take_word(w)) n_effective++;
    @(negedge clk);
  endtask

  task automatic write_steps(logic [rlf_pkg::STEP_W-1:0] v);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.steps_reg = v;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_duty(out_data);
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_rgb_linear_fade_engine: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit held;
    sb = new();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    write_steps(8'd2);
    send_word(mk_word(rlf_pkg::MODE_TICK, '1, '1, '1));            // idle tick: drop
    send_word(mk_word(MODE_SPARE, 8'h5a, 8'ha5, 8'h0f));           // unused mode: drop
    send_word(mk_word(rlf_pkg::MODE_COND, '0, '0, '0));            // same as start: drop
    send_word(mk_word(rlf_pkg::MODE_TICK, 8'h00, 8'hff, 8'h3c));
    send_word(mk_word(rlf_pkg::MODE_COND, '1, '1, '1));
    repeat (4) send_word(mk_word(rlf_pkg::MODE_TICK, 8'hc3, 8'h3c, 8'h81));
    send_word(mk_word(rlf_pkg::MODE_FORCE, '0, '1, '0));
    send_word(mk_word(rlf_pkg::MODE_TICK, 8'h7e, 8'h18, 8'he7));
    send_word(mk_word(rlf_pkg::MODE_COND, 8'haa, 8'h55, 8'haa));   // fade running: drop
    send_word(mk_word(rlf_pkg::MODE_FORCE, '1, '0, '1));           // restart mid-fade
    repeat (3) send_word(mk_word(rlf_pkg::MODE_TICK, '0, '0, '0));
    send_word(mk_word(rlf_pkg::MODE_COND, '1, '0, '1));            // equals new start: drop
    write_steps(8'd0);
    send_word(mk_word(rlf_pkg::MODE_FORCE, 8'h80, 8'h7f, 8'h01));
    repeat (3) send_word(mk_word(rlf_pkg::MODE_TICK, '1, '1, '1));

    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_idle_pct = (p < 3) ? 32 : (p < 6) ? 45 : 0;
      rx_idle_pct = (p < 3) ? 45 : (p < 6) ? 32 : 0;
      write_steps(PHASE_STEPS[p]);
      n_effective = 0;
      held = 1'b0;
      while (n_effective < PHASE_WORDS[p]) begin
        // back up the output so the engine stalls its input
        if ((p == 1 || p == 6) && !held && n_effective >= 20) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        send_word(pick_word());
      end
    end

    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
    $display("checked %0d duty words from %0d fade loads, %0d fades run to the end,",
             sb.n_checked, sb.n_loads, sb.n_fades);
    $display("fade lengths 0 to 255, idle and stall on both sides, long output hold-off");
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("tb_rgb_linear_fade_engine: done, clean");
    end else begin
      $display("tb_rgb_linear_fade_engine: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/rlf_pkg.sv
hdl/rlf_lane.sv
hdl/rgb_linear_fade_engine.sv
hdl/rlf_checker.sv
dv/tb_rgb_linear_fade_engine.sv
